[hdl/sai_pkg.sv]
// Shared types, constants and codes for the sorted array insert/search block.
`timescale 1ns / 1ps
package sai_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam logic OP_FIND   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic signed [VALUE_W-1:0] value;
  } sai_in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             accepted;
    logic [POS_W-1:0] fill_count;
  } sai_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_RESOLVE,
    ST_SHIFT,
    ST_STORE,
    ST_DONE
  } sai_state_e;

  typedef struct packed {
    logic load;
    logic probe;
    logic miss;
    logic compare;
    logic resolve;
    logic shift_step;
    logic store;
    logic publish;
  } sai_cmd_t;

  typedef struct packed {
    logic live;
    logic hit;
    logic do_insert;
    logic shift_more;
  } sai_status_t;

endpackage

[hdl/sai_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sai_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/sai_datapath.sv]
// Datapath: search bounds, shift pointers, entry RAM, count and result register.
`timescale 1ns / 1ps
module sai_datapath
  import sai_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sai_in_t     in_item_i,
  input  sai_cmd_t    cmd_i,
  output sai_status_t status_o,
  output sai_out_t    out_item_o
);

  logic signed [VALUE_W-1:0] key_q;
  logic                      op_q;
  logic [CNT_W-1:0]          lo_q, lo_d;
  logic [CNT_W-1:0]          hi1_q, hi1_d;
  logic [CNT_W-1:0]          mid_q;
  logic [CNT_W-1:0]          pos_q, pos_d;
  logic                      found_q, found_d;
  logic                      accepted_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          rd_ptr_q, rd_ptr_d;
  logic [IDX_W-1:0]          wr_addr_q;
  logic                      pend_q, pend_d;
  sai_out_t                  out_q;

  logic [CNT_W:0]            mid_sum;
  logic [CNT_W-1:0]          mid_c;
  logic [CNT_W-1:0]          rd_ptr_m1;
  logic signed [VALUE_W-1:0] rdata;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [IDX_W-1:0]          ram_raddr;
  logic [VALUE_W-1:0]        ram_wdata;
  logic [VALUE_W-1:0]        ram_rdata;

  // floor((lo + hi) / 2) with hi = hi1 - 1; only used while lo < hi1
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi1_q} - (CNT_W + 1)'(1);
  assign mid_c     = mid_sum[CNT_W:1];
  assign rd_ptr_m1 = rd_ptr_q - CNT_W'(1);
  assign rdata     = ram_rdata;

  assign status_o.live       = lo_q < hi1_q;
  assign status_o.hit        = rdata == key_q;
  assign status_o.do_insert  = (op_q == OP_INSERT) && (count_q < CNT_W'(CAPACITY));
  assign status_o.shift_more = rd_ptr_q > pos_q;

  assign ram_raddr = cmd_i.probe ? mid_c[IDX_W-1:0] : rd_ptr_m1[IDX_W-1:0];
  assign ram_we    = (cmd_i.shift_step && pend_q) || cmd_i.store;
  assign ram_waddr = cmd_i.store ? pos_q[IDX_W-1:0] : wr_addr_q;
  assign ram_wdata = cmd_i.store ? key_q : ram_rdata;

  sai_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    lo_d     = lo_q;
    hi1_d    = hi1_q;
    pos_d    = pos_q;
    found_d  = found_q;
    count_d  = count_q;
    rd_ptr_d = rd_ptr_q;
    pend_d   = pend_q;
    if (cmd_i.load) begin
      lo_d  = '0;
      hi1_d = count_q;
    end
    if (cmd_i.miss) begin
      found_d = 1'b0;
      pos_d   = lo_q;
    end
    if (cmd_i.compare) begin
      if (rdata == key_q) begin
        found_d = 1'b1;
        pos_d   = mid_q;
      end else if (key_q < rdata) begin
        hi1_d = mid_q;
      end else begin
        lo_d = mid_q + CNT_W'(1);
      end
    end
    if (cmd_i.resolve) begin
      rd_ptr_d = count_q;
      pend_d   = 1'b0;
    end
    if (cmd_i.shift_step) begin
      // move entry rd_ptr-1 up to rd_ptr, one read per cycle
      pend_d = status_o.shift_more;
      if (status_o.shift_more) begin
        rd_ptr_d = rd_ptr_m1;
      end
    end
    if (cmd_i.store) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi1_q    <= hi1_d;
    pos_q    <= pos_d;
    found_q  <= found_d;
    rd_ptr_q <= rd_ptr_d;
    if (cmd_i.load) begin
      key_q <= in_item_i.value;
      op_q  <= in_item_i.opcode;
    end
    if (cmd_i.probe) begin
      mid_q <= mid_c;
    end
    if (cmd_i.resolve) begin
      accepted_q <= !((op_q == OP_INSERT) && (count_q >= CNT_W'(CAPACITY)));
    end
    if (cmd_i.shift_step && status_o.shift_more) begin
      wr_addr_q <= rd_ptr_q[IDX_W-1:0];
    end
    if (cmd_i.publish) begin
      out_q.found      <= found_q;
      out_q.position   <= POS_W'(pos_q);
      out_q.accepted   <= accepted_q;
      out_q.fill_count <= POS_W'(count_q);
    end
  end

  assign out_item_o = out_q;

endmodule

[hdl/sai_ctrl.sv]
// Controller state machine: sequences search, shift, store and result handoff.
`timescale 1ns / 1ps
module sai_ctrl
  import sai_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  sai_status_t status_i,
  output sai_cmd_t    cmd_o
);

  sai_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_busy;

  assign out_busy = out_valid_q && out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_SEARCH;
      ST_SEARCH:  state_d = status_i.live ? ST_COMPARE : ST_RESOLVE;
      ST_COMPARE: state_d = status_i.hit ? ST_RESOLVE : ST_SEARCH;
      ST_RESOLVE: state_d = status_i.do_insert ? ST_SHIFT : ST_DONE;
      ST_SHIFT:   if (!status_i.shift_more) state_d = ST_STORE;
      ST_STORE:   state_d = ST_DONE;
      ST_DONE:    if (!out_busy) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:    cmd_o.load       = in_valid_i;
      ST_SEARCH: begin
        cmd_o.probe = status_i.live;
        cmd_o.miss  = !status_i.live;
      end
      ST_COMPARE: cmd_o.compare    = 1'b1;
      ST_RESOLVE: cmd_o.resolve    = 1'b1;
      ST_SHIFT:   cmd_o.shift_step = 1'b1;
      ST_STORE:   cmd_o.store      = 1'b1;
      ST_DONE:    cmd_o.publish    = !out_busy;
      default:    cmd_o = '0;
    endcase
  end

  assign out_valid_d = cmd_o.publish || out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

[hdl/sorted_array_insert_search.sv]
// Top level: sorted array with binary search and ordered insert.
// Sequence: accept, binary search of S probes (at most ceil(log2(count+1)), 6 when full),
//   a final miss step when the search misses, then for an accepted insert one RAM read per
//   moved entry from the top down to the position, then the store, then the result.
//   A result still stalled at the output holds the block until the consumer takes it.
// Throughput: one item at a time; an insert at position 0 moves every stored entry.
// Reset: count clears to zero; entry RAM contents stay undefined and are never read
//   before being written.
`timescale 1ns / 1ps
module sorted_array_insert_search
  import sai_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sai_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sai_out_t out_item_o
);

  sai_cmd_t    cmd;
  sai_status_t status;

  // Controller: accept in idle, walk the search probes, drive the shift loop,
  // then hand the result to the output register. A new item is taken as soon
  // as the result is loaded, even while the consumer still stalls it.
  sai_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: one probe read per search/compare step during search, one entry moved
  // per cycle during the shift (read below, write one above, overlapped).
  sai_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_item_o(out_item_o)
  );

  // Refusal only happens to an insert into a full array.
  a_refuse_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.accepted |-> out_item_o.fill_count == POS_W'(CAPACITY))
    else $error("refused item while array not full");

  // Position never lies beyond the stored entries.
  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.position <= out_item_o.fill_count)
    else $error("position beyond fill count");

  // Fill count never exceeds capacity.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.fill_count <= POS_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // The controller only reaches the result handoff with the input side closed.
  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> in_stall_o)
    else $error("result published while accepting");

endmodule

[tb/sai_checker.sv]
`timescale 1ns / 1ps
// Checker: watches both channels, predicts each result and compares it field by field.
module sai_checker
  import sai_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  sai_in_t     in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  sai_out_t    out_item_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  logic signed [VALUE_W-1:0] sorted_keys [CAPACITY];
  int unsigned               key_count;
  sai_out_t                  expected_results [$];
  sai_out_t                  oldest;
  int unsigned               fail_count;

  initial begin
    foreach (sorted_keys[i]) sorted_keys[i] = '0;
    key_count    = 0;
    fail_count   = 0;
    mismatches_o = 0;
    pending_o    = 0;
  end

  // Search the stored keys, then insert when asked and there is room.
  function automatic sai_out_t search_and_insert(sai_in_t it);
    logic signed [VALUE_W-1:0] key;
    int                        lo;
    int                        hi;
    int                        mid;
    int                        pos;
    int                        idx;
    logic                      hit;
    sai_out_t                  res;
    key = it.value;
    lo  = 0;
    hi  = int'(key_count) - 1;
    mid = 0;
    hit = 1'b0;
    while (!hit && lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (key == sorted_keys[mid]) hit = 1'b1;
      else if (key < sorted_keys[mid]) hi = mid - 1;
      else lo = mid + 1;
    end
    pos          = hit ? mid : lo;
    res.found    = hit;
    res.position = POS_W'(pos);
    res.accepted = 1'b1;
    if (it.opcode == OP_INSERT) begin
      if (key_count >= CAPACITY) begin
        res.accepted = 1'b0;
      end else begin
        for (idx = int'(key_count); idx > pos; idx--) sorted_keys[idx] = sorted_keys[idx-1];
        sorted_keys[pos] = key;
        key_count++;
      end
    end
    res.fill_count = POS_W'(key_count);
    return res;
  endfunction

  task automatic flag_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Results first, so a stray result is never matched to an item taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %p", $time, out_item_i);
          fail_count++;
        end else begin
          oldest = expected_results.pop_front();
          flag_field("found", oldest.found, out_item_i.found);
          flag_field("position", oldest.position, out_item_i.position);
          flag_field("accepted", oldest.accepted, out_item_i.accepted);
          flag_field("fill_count", oldest.fill_count, out_item_i.fill_count);
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(search_and_insert(in_item_i));
      mismatches_o = fail_count;
      pending_o    = expected_results.size();
    end
  end

endmodule

[tb/sorted_array_insert_search_tb.sv]
`timescale 1ns / 1ps
// Testbench top: stimulus, flow control on both channels and the final verdict.
module sorted_array_insert_search_tb;
  import sai_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1750;
  localparam int unsigned MAX_WAIT      = 17;
  // Slowest result: an insert at position 0 into 31 entries.
  localparam int unsigned SETTLE_CYCLES = 64;
  // Worst run: 1770 items, each with its longest gap, search and stall, ends well before the limit.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  localparam logic signed [VALUE_W-1:0] KEY_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] KEY_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  sai_in_t     in_item_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  sai_out_t    out_item_o;

  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned cycle_count = 0;

  // Quiet flags switch a side into back-to-back mode for a stretch of items.
  logic        tx_quiet    = 1'b0;
  logic        rx_quiet    = 1'b0;
  int unsigned rx_hold     = 0;
  int unsigned rx_draw;

  // Keys sent as inserts; random keys are often drawn from here to hit duplicates.
  logic signed [VALUE_W-1:0] inserted_keys [$];

  always #6 clk_i = ~clk_i;

  sorted_array_insert_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  sai_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .mismatches_o (mismatch_count),
    .pending_o    (results_pending)
  );

  function automatic int unsigned draw_wait(input logic quiet);
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Mix of full-range keys, stored keys, their neighbors and a small band around zero.
  function automatic logic signed [VALUE_W-1:0] pick_key();
    int unsigned               choice;
    logic signed [VALUE_W-1:0] k;
    choice = $urandom_range(0, 3);
    k      = $urandom;
    if (choice == 3) begin
      k = VALUE_W'($urandom_range(0, 8)) - 4;
    end else if (choice != 0 && inserted_keys.size() != 0) begin
      k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      if (choice == 2) k = $urandom_range(0, 1) ? k + 1 : k - 1;
    end
    return k;
  endfunction

  // Wait out the drawn gap, present the item and hold it until the block takes it.
  // Valid drops only when a gap follows, so back-to-back items keep it high.
  task automatic send_item(input logic op, input logic signed [VALUE_W-1:0] key);
    int unsigned gap;
    gap = draw_wait(tx_quiet);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{opcode: op, value: key};
    do @(posedge clk_i); while (in_stall_o);
    if (op == OP_INSERT) inserted_keys.push_back(key);
    if ($urandom_range(0, 49) == 0) tx_quiet = ~tx_quiet;
  endtask

  // Receiver: after each taken result, stall for a drawn number of cycles.
  // The stall runs whether or not a result is waiting, so it lands on every phase.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if ($urandom_range(0, 63) == 0) rx_quiet <= ~rx_quiet;
      rx_draw = draw_wait(rx_quiet);
      rx_hold     <= rx_draw;
      out_stall_i <= (rx_draw != 0);
    end else if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_hold     <= 0;
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Searches on the empty array.
    send_item(OP_FIND, '0);
    send_item(OP_FIND, KEY_MIN);
    send_item(OP_FIND, KEY_MAX);
    // Extremes, then duplicates at the middle, the top and the bottom.
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, KEY_MAX);
    send_item(OP_INSERT, KEY_MIN);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, KEY_MAX);
    send_item(OP_INSERT, KEY_MIN);
    // Hits and misses around the stored keys.
    send_item(OP_FIND, '0);
    send_item(OP_FIND, KEY_MAX);
    send_item(OP_FIND, KEY_MIN);
    send_item(OP_FIND, -1);
    send_item(OP_FIND, 1);
    send_item(OP_FIND, KEY_MAX - 1);
    send_item(OP_FIND, KEY_MIN + 1);
    send_item(OP_INSERT, -1);
    send_item(OP_INSERT, 1);
    send_item(OP_FIND, 32'sh5555_5555);
    send_item(OP_FIND, 32'shAAAA_AAAA);

    // Random mix: the array fills early, after which inserts are refused while
    // finds keep probing a full array with hits, neighbors and far misses.
    repeat (RANDOM_ITEMS) begin
      send_item(($urandom_range(0, 3) == 0) ? OP_INSERT : OP_FIND, pick_key());
    end
    in_valid_i <= 1'b0;

    // Drain, then give the block time to show any stray result.
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
